// ===== sv/bedp_pkg.sv =====
package bedp_pkg;

  localparam int ID_W    = 6;
  localparam int ID_SPAN = 2 ** ID_W;
  localparam int CAP_W   = 17;
  localparam int STAMP_W = 64;
  localparam int PAIR_W  = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

  localparam logic [1:0] KIND_BEGIN = 2'd0;

  localparam logic [2:0] ST_BEGIN     = 3'd0;
  localparam logic [2:0] ST_PAIRED    = 3'd1;
  localparam logic [2:0] ST_UNMATCHED = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_NEST_FULL = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC,
    S_STK,
    S_UPD
  } state_e;

  typedef struct packed {
    logic [PAIR_W-1:0]  pairs;
    logic [STAMP_W-1:0] total;
    logic [STAMP_W-1:0] least;
    logic [STAMP_W-1:0] most;
  } stat_t;

  // least and most mean nothing until the section has a pair
  function automatic stat_t shown_stats(input stat_t s);
    stat_t r;
    r = s;
    if (s.pairs == '0) begin
      r.least = '0;
      r.most  = '0;
    end
    return r;
  endfunction

endpackage

// ===== sv/bedp_ram.sv =====
module bedp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bedp_stat_upd.sv =====
module bedp_stat_upd
  import bedp_pkg::*;
(
  input  stat_t              cur_i,
  input  logic [STAMP_W-1:0] dur_i,
  output stat_t              nxt_o
);

  logic [STAMP_W:0] sum_wide;
  logic             first_pair;

  assign sum_wide   = {1'b0, cur_i.total} + {1'b0, dur_i};
  assign first_pair = (cur_i.pairs == '0);

  always_comb begin
    nxt_o = cur_i;
    nxt_o.total = sum_wide[STAMP_W] ? '1 : sum_wide[STAMP_W-1:0];
    if (cur_i.pairs != '1) begin
      nxt_o.pairs = cur_i.pairs + 1'b1;
    end
    if (first_pair || (dur_i < cur_i.least)) begin
      nxt_o.least = dur_i;
    end
    if (first_pair || (dur_i > cur_i.most)) begin
      nxt_o.most = dur_i;
    end
  end

endmodule

// ===== sv/begin_end_duration_profiler_core.sv =====
// Profiles begin/end event pairs per section. An item is taken when start is high and busy low.
// Clear, dropped and out-of-range items end in S_IDLE, begins and unmatched ends in S_REC, and
// paired ends in S_UPD: the section record memory is read first, and its stack depth then
// addresses the begin stamp memory, whose word feeds the subtract and the statistics update.
// Each result shows on the result ports for one cycle with out_valid_o, in the cycle after
// the item's last work cycle; the receiver has no way to hold it and must take it then. Records
// are cleared at once by a clear item or reset through per-section valid flags, so there is
// no clearing pass. The capacity register may be written whenever the block is idle.
module begin_end_duration_profiler_core
  import bedp_pkg::*;
#(
  parameter int NUM_SECTIONS = 64,
  parameter int NEST_DEPTH   = 8,
  parameter int MAX_EVENTS   = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [ID_W-1:0]    section_id_i,
  input  logic [STAMP_W-1:0] stamp_ns_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [ID_W-1:0]    result_id_o,
  output logic [STAMP_W-1:0] duration_ns_o,
  output logic [PAIR_W-1:0]  pair_count_o,
  output logic [STAMP_W-1:0] duration_total_o,
  output logic [STAMP_W-1:0] duration_least_o,
  output logic [STAMP_W-1:0] duration_most_o
);

  // only ids the id field can carry get a record
  localparam int ROWS      = (NUM_SECTIONS < ID_SPAN) ? NUM_SECTIONS : ID_SPAN;
  localparam int SEC_W     = $clog2(ROWS);
  localparam int DEP_W     = $clog2(NEST_DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_EVENTS + 1);
  localparam int STK_DEPTH = ROWS * NEST_DEPTH;
  localparam int STK_W     = $clog2(STK_DEPTH);
  localparam int STAT_W    = $bits(stat_t);
  localparam int REC_W     = DEP_W + STAT_W;

  state_e state_q, state_d;

  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   taken_q, taken_d;
  logic [ROWS-1:0]    valid_q;

  logic               is_end_q;
  logic [SEC_W-1:0]   sec_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [DEP_W-1:0]   depth_q, depth_d;
  stat_t              stat_q, stat_d;
  logic [STAMP_W-1:0] dur_q, dur_d;

  logic               res_valid_q;
  logic [2:0]         res_status_q, res_status_d;
  logic [ID_W-1:0]    res_id_q;
  logic [STAMP_W-1:0] res_dur_q, res_dur_d;
  stat_t              res_stat_q, res_stat_d;
  logic               res_load;

  logic               accept;
  logic               take_ok;
  logic               out_range;
  logic [31:0]        limit;

  logic               rec_we, rec_re;
  logic [REC_W-1:0]   rec_wdata, rec_rdata;
  logic [SEC_W-1:0]   rec_raddr;
  logic [DEP_W-1:0]   cur_depth;
  stat_t              cur_stat;
  stat_t              nxt_stat;

  logic               stk_we, stk_re;
  logic [STK_W-1:0]   stk_waddr, stk_raddr;
  logic [STAMP_W-1:0] stk_rdata;

  function automatic logic [STK_W-1:0] stk_addr(input logic [SEC_W-1:0] sec,
                                                 input logic [DEP_W-1:0] dep);
    return STK_W'(32'(sec) * NEST_DEPTH + 32'(dep));
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign limit     = (32'(cap_q) < MAX_EVENTS) ? 32'(cap_q) : MAX_EVENTS;
  assign take_ok   = (32'(taken_q) < limit);
  assign out_range = ({1'b0, section_id_i} >= 7'(ROWS));
  assign rec_raddr = section_id_i[SEC_W-1:0];

  // a record never written since the last clear reads as empty
  assign cur_depth = valid_q[sec_q] ? rec_rdata[REC_W-1 -: DEP_W] : '0;
  assign cur_stat  = valid_q[sec_q] ? stat_t'(rec_rdata[STAT_W-1:0]) : '0;

  bedp_ram #(
    .WIDTH (REC_W),
    .DEPTH (ROWS)
  ) u_rec_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (sec_q),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  bedp_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (STK_DEPTH)
  ) u_stk_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stamp_q),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  bedp_stat_upd u_stat_upd (
    .cur_i (stat_q),
    .dur_i (dur_q),
    .nxt_o (nxt_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !kind_i[1] && take_ok && !out_range) begin
          state_d = S_REC;
        end
      end
      S_REC: begin
        if (is_end_q && (cur_depth != '0)) begin
          state_d = S_STK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_STK:   state_d = S_UPD;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory control, datapath and result loads
  always_comb begin
    rec_re       = 1'b0;
    rec_we       = 1'b0;
    rec_wdata    = {cur_depth, cur_stat};
    stk_we       = 1'b0;
    stk_waddr    = stk_addr(sec_q, cur_depth);
    stk_re       = 1'b0;
    stk_raddr    = stk_addr(sec_q, cur_depth - 1'b1);
    taken_d      = taken_q;
    depth_d      = depth_q;
    stat_d       = stat_q;
    dur_d        = dur_q;
    res_load     = 1'b0;
    res_status_d = ST_CLEARED;
    res_dur_d    = '0;
    res_stat_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i[1]) begin
            taken_d  = '0;
            res_load = 1'b1;
          end else if (!take_ok) begin
            res_load     = 1'b1;
            res_status_d = ST_DROPPED;
          end else begin
            taken_d = taken_q + 1'b1;
            if (out_range) begin
              res_load     = 1'b1;
              res_status_d = (kind_i == KIND_BEGIN) ? ST_NEST_FULL : ST_UNMATCHED;
            end else begin
              rec_re = 1'b1;
            end
          end
        end
      end
      S_REC: begin
        res_stat_d = shown_stats(cur_stat);
        if (!is_end_q) begin
          res_load = 1'b1;
          if (32'(cur_depth) >= NEST_DEPTH) begin
            res_status_d = ST_NEST_FULL;
          end else begin
            res_status_d = ST_BEGIN;
            stk_we       = 1'b1;
            rec_we       = 1'b1;
            rec_wdata    = {cur_depth + 1'b1, cur_stat};
          end
        end else if (cur_depth == '0) begin
          res_load     = 1'b1;
          res_status_d = ST_UNMATCHED;
        end else begin
          stk_re  = 1'b1;
          depth_d = cur_depth - 1'b1;
          stat_d  = cur_stat;
        end
      end
      S_STK: begin
        dur_d = stamp_q - stk_rdata;
      end
      S_UPD: begin
        rec_we       = 1'b1;
        rec_wdata    = {depth_q, nxt_stat};
        res_load     = 1'b1;
        res_status_d = ST_PAIRED;
        res_dur_d    = dur_q;
        res_stat_d   = nxt_stat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      taken_q     <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      res_valid_q <= res_load;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept && kind_i[1]) begin
        valid_q <= '0;
      end else if (rec_we) begin
        valid_q[sec_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    stat_q  <= stat_d;
    dur_q   <= dur_d;
    if (accept) begin
      is_end_q <= kind_i[0];
      sec_q    <= section_id_i[SEC_W-1:0];
      stamp_q  <= stamp_ns_i;
      res_id_q <= section_id_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_dur_q    <= res_dur_d;
      res_stat_q   <= res_stat_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign status_o         = res_status_q;
  assign result_id_o      = res_id_q;
  assign duration_ns_o    = res_dur_q;
  assign pair_count_o     = res_stat_q.pairs;
  assign duration_total_o = res_stat_q.total;
  assign duration_least_o = res_stat_q.least;
  assign duration_most_o  = res_stat_q.most;

  a_clear_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i[1] |=> out_valid_o && (status_o == ST_CLEARED))
    else $error("clear item did not report cleared");

  a_update_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |=> out_valid_o && (status_o == ST_PAIRED) && !busy)
    else $error("paired end did not report");

  a_pair_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_PAIRED) |->
      (pair_count_o != '0) && (duration_least_o <= duration_most_o))
    else $error("paired statistics inconsistent");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(taken_q) <= MAX_EVENTS)
    else $error("event count beyond limit");

endmodule

// ===== verif/tb_begin_end_duration_profiler_core.sv =====
module tb_begin_end_duration_profiler_core
  import bedp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEST = 8;
  localparam logic [CAP_W-1:0] EVENT_LIMIT = 17'h10000;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_CLEAR     = 2'd2;
  localparam logic [1:0] KIND_CLEAR_ALT = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    sec;
    logic [STAMP_W-1:0] stamp;
    logic               hold;   // wait for every pending result before sending
  } trace_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] dur;
    logic [PAIR_W-1:0]  pairs;
    logic [STAMP_W-1:0] total;
    logic [STAMP_W-1:0] least;
    logic [STAMP_W-1:0] most;
  } section_report_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic               busy;
  logic [1:0]         kind_i       = '0;
  logic [ID_W-1:0]    section_id_i = '0;
  logic [STAMP_W-1:0] stamp_ns_i   = '0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CAP_W-1:0]   cfg_data_i   = '0;
  logic               out_valid_o;
  logic [2:0]         status_o;
  logic [ID_W-1:0]    result_id_o;
  logic [STAMP_W-1:0] duration_ns_o;
  logic [PAIR_W-1:0]  pair_count_o;
  logic [STAMP_W-1:0] duration_total_o;
  logic [STAMP_W-1:0] duration_least_o;
  logic [STAMP_W-1:0] duration_most_o;

  begin_end_duration_profiler_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .section_id_i     (section_id_i),
    .stamp_ns_i       (stamp_ns_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .result_id_o      (result_id_o),
    .duration_ns_o    (duration_ns_o),
    .pair_count_o     (pair_count_o),
    .duration_total_o (duration_total_o),
    .duration_least_o (duration_least_o),
    .duration_most_o  (duration_most_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // profiler state as predicted
  logic [CAP_W-1:0]   capacity_q  = CAP_RESET;
  logic [CAP_W-1:0]   taken_cnt   = '0;
  logic [3:0]         open_cnt  [ID_SPAN]       = '{default: '0};
  logic [STAMP_W-1:0] stamp_mem [ID_SPAN][NEST] = '{default: '0};
  logic [PAIR_W-1:0]  pair_cnt  [ID_SPAN]       = '{default: '0};
  logic [STAMP_W-1:0] total_mem [ID_SPAN]       = '{default: '0};
  logic [STAMP_W-1:0] least_mem [ID_SPAN]       = '{default: '0};
  logic [STAMP_W-1:0] most_mem  [ID_SPAN]       = '{default: '0};

  trace_item_t     trace_q[$];
  section_report_t stats_due[$];
  trace_item_t     next_item;
  section_report_t want;
  logic [STAMP_W-1:0] clock_ns = '0;
  int  mismatch_count = 0;
  int  sent_count     = 0;
  logic item_taken = 1'b0;
  logic cfg_hit    = 1'b0;

  function automatic section_report_t profile_event(input logic [1:0] kind,
                                                    input logic [ID_W-1:0] sec,
                                                    input logic [STAMP_W-1:0] stamp);
    section_report_t r;
    logic [CAP_W-1:0] lim;
    int d;
    logic [STAMP_W-1:0] dur;
    r = '0;
    r.id = sec;
    if (kind[1]) begin
      taken_cnt = '0;
      for (int i = 0; i < ID_SPAN; i++) begin
        open_cnt[i]  = '0;
        pair_cnt[i]  = '0;
        total_mem[i] = '0;
      end
      r.status = ST_CLEARED;
      return r;
    end
    lim = (capacity_q < EVENT_LIMIT) ? capacity_q : EVENT_LIMIT;
    if (taken_cnt >= lim) begin
      r.status = ST_DROPPED;
      return r;
    end
    taken_cnt++;
    d = open_cnt[sec];
    if (kind == KIND_BEGIN) begin
      if (d >= NEST) begin
        r.status = ST_NEST_FULL;
      end else begin
        stamp_mem[sec][d] = stamp;
        open_cnt[sec] = 4'(d + 1);
        r.status = ST_BEGIN;
      end
    end else if (d == 0) begin
      r.status = ST_UNMATCHED;
    end else begin
      d--;
      open_cnt[sec] = 4'(d);
      dur = stamp - stamp_mem[sec][d];
      if (pair_cnt[sec] == '0) begin
        least_mem[sec] = dur;
        most_mem[sec]  = dur;
      end else begin
        if (dur < least_mem[sec]) least_mem[sec] = dur;
        if (dur > most_mem[sec]) most_mem[sec] = dur;
      end
      if (pair_cnt[sec] != '1) pair_cnt[sec]++;
      // saturating sum
      if (total_mem[sec] > ~dur) total_mem[sec] = '1;
      else total_mem[sec] += dur;
      r.status = ST_PAIRED;
      r.dur    = dur;
    end
    r.pairs = pair_cnt[sec];
    r.total = total_mem[sec];
    if (pair_cnt[sec] != '0) begin
      r.least = least_mem[sec];
      r.most  = most_mem[sec];
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o) begin
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d id %0d",
                   $time, status_o, result_id_o);
          mismatch_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("status", 64'(want.status), 64'(status_o));
          check_field("result_id", 64'(want.id), 64'(result_id_o));
          check_field("duration_ns", want.dur, duration_ns_o);
          check_field("pair_count", 64'(want.pairs), 64'(pair_count_o));
          check_field("duration_total", want.total, duration_total_o);
          check_field("duration_least", want.least, duration_least_o);
          check_field("duration_most", want.most, duration_most_o);
        end
      end
      if (start && !busy) begin
        stats_due.push_back(profile_event(kind_i, section_id_i, stamp_ns_i));
        item_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q = cfg_data_i;
        cfg_hit = 1'b1;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start || item_taken)) begin
      if (trace_q.size() != 0 && (!trace_q[0].hold || stats_due.size() == 0) &&
          $urandom_range(0, 99) >= ((sent_count >= 700 && sent_count < 1000) ? 0 : 33)) begin
        next_item = trace_q.pop_front();
        kind_i       <= next_item.kind;
        section_id_i <= next_item.sec;
        stamp_ns_i   <= next_item.stamp;
        start        <= 1'b1;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  task automatic add_item(input logic [1:0] k, input logic [ID_W-1:0] s,
                          input logic [STAMP_W-1:0] stamp, input logic hold = 1'b0);
    trace_q.push_back('{k, s, stamp, hold});
  endtask

  // mostly well-formed begin/end nesting on a few busy sections, plus noise
  task automatic add_random(input int n);
    logic [ID_W-1:0] hot [4];
    logic [3:0] plan [ID_SPAN];
    logic [ID_W-1:0] s;
    logic [1:0] k;
    int r;
    for (int i = 0; i < 4; i++) hot[i] = ID_W'($urandom_range(0, ID_SPAN - 1));
    for (int i = 0; i < ID_SPAN; i++) plan[i] = '0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 4) == 0) ? ID_W'($urandom) : hot[$urandom_range(0, 3)];
      if ($urandom_range(0, 19) == 0) clock_ns = {$urandom, $urandom};
      else clock_ns += 64'($urandom_range(0, 1500));
      if (r < 2) begin
        k = ($urandom_range(0, 1) == 0) ? KIND_CLEAR : KIND_CLEAR_ALT;
        for (int j = 0; j < ID_SPAN; j++) plan[j] = '0;
      end else if (r < 8) begin
        k = ($urandom_range(0, 1) == 0) ? KIND_BEGIN : KIND_END;
      end else if (plan[s] == 0) begin
        k = KIND_BEGIN;
      end else if (plan[s] == NEST) begin
        k = ($urandom_range(0, 9) == 0) ? KIND_BEGIN : KIND_END;
      end else begin
        k = ($urandom_range(0, 1) == 0) ? KIND_BEGIN : KIND_END;
      end
      if (k == KIND_BEGIN && plan[s] < NEST) plan[s]++;
      else if (k == KIND_END && plan[s] != 0) plan[s]--;
      add_item(k, s, clock_ns, $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (trace_q.size() != 0 || start || stats_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_hit);
    cfg_valid_i <= 1'b0;
    cfg_hit = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // widest duration, then a wrapped one that saturates the sum
    add_item(KIND_BEGIN, 6'd0, 64'd0);
    add_item(KIND_END, 6'd0, '1);
    add_item(KIND_BEGIN, 6'd0, 64'd10);
    add_item(KIND_END, 6'd0, 64'd3);
    add_item(KIND_END, 6'd0, 64'd5);
    add_item(KIND_BEGIN, 6'd63, '1);
    add_item(KIND_END, 6'd63, 64'd0);
    // fill one stack past its depth, then pop twice
    for (int i = 0; i < NEST + 1; i++) add_item(KIND_BEGIN, 6'd5, 64'(100 + 37 * i));
    add_item(KIND_END, 6'd5, 64'd1000);
    add_item(KIND_END, 6'd5, 64'd2000);
    add_item(KIND_CLEAR_ALT, 6'd63, 64'h5a5a_a5a5_0f0f_f0f0);
    add_item(KIND_END, 6'd5, 64'd2100);
    add_item(KIND_BEGIN, 6'd5, 64'd7);
    add_item(KIND_CLEAR, 6'd0, 64'd0);
    add_item(KIND_END, 6'd5, 64'd9);

    // no room at all: everything but clear is dropped
    write_capacity('0);
    add_item(KIND_BEGIN, 6'd1, 64'd1);
    add_item(KIND_END, 6'd1, 64'd2);
    add_item(KIND_CLEAR, 6'd1, 64'd3);
    add_item(KIND_BEGIN, 6'd1, 64'd4);
    add_item(KIND_END, 6'd1, 64'd5, 1'b1);

    // room for one event between clears
    write_capacity(17'd1);
    add_item(KIND_BEGIN, 6'd7, 64'd10);
    add_item(KIND_END, 6'd7, 64'd20);
    add_item(KIND_CLEAR, 6'd7, 64'd30);
    add_item(KIND_END, 6'd7, 64'd40);
    add_item(KIND_BEGIN, 6'd7, 64'd50);

    write_capacity('1);
    add_random(700);

    write_capacity(CAP_W'($urandom_range(5, 60)));
    add_random(400);

    write_capacity(EVENT_LIMIT);
    add_random(600);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && stats_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
